FILE: rtl/core/packed_pixel_span_raster_op_core_macros.svh
// Assertion macros used by the checker file of the span raster-op core.
// No dependencies; include by bare file name.
`ifndef PACKED_PIXEL_SPAN_RASTER_OP_CORE_MACROS_SVH
`define PACKED_PIXEL_SPAN_RASTER_OP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppsr assertion failed");

// Next-cycle implication, disabled during reset.
`define PPSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppsr assertion failed");

// Next-cycle implication, active through reset.
`define PPSR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ppsr assertion failed");

`endif

FILE: rtl/core/ppsr_pkg.sv
// Package for the packed-pixel span raster-op core: types, codes, helpers.
// No dependencies.
package ppsr_pkg;

    localparam int WORD_BITS = 32;
    localparam int SH_W      = 5;
    localparam int IDX_W     = 26;
    localparam int CNT_W     = 12;
    localparam int PROD_W    = 25;
    localparam int XBITS_W   = 17;

    localparam logic [1:0] KIND_WR_WORD = 2'd0;
    localparam logic [1:0] KIND_RD_WORD = 2'd1;
    localparam logic [1:0] KIND_SPAN    = 2'd2;
    localparam logic [1:0] KIND_RD_PIX  = 2'd3;

    localparam logic [2:0] PEN_ASSIGN     = 3'd0;
    localparam logic [2:0] PEN_ERASE      = 3'd1;
    localparam logic [2:0] PEN_INVERT     = 3'd2;
    localparam logic [2:0] PEN_BLEND      = 3'd3;
    localparam logic [2:0] PEN_ZERO_TRANS = 3'd4;

    localparam logic [1:0] CFG_BPP_LOG2  = 2'd0;
    localparam logic [1:0] CFG_ROW_WORDS = 2'd1;
    localparam logic [1:0] CFG_PEN_MODE  = 2'd2;

    localparam logic [2:0] BPP_LOG2_MAX = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_ISSUE,
        ST_RDATA,
        ST_SPAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]           pen;
        logic [WORD_BITS-1:0] field;
        logic [WORD_BITS-1:0] nz;
        logic [WORD_BITS-1:0] pattern;
    } t_merge_ctl;

    // Mask of the low n bits, n in 0..32.
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [5:0] n);
        logic [WORD_BITS:0] t;
        t = ({{WORD_BITS{1'b0}}, 1'b1} << n) - {{WORD_BITS{1'b0}}, 1'b1};
        return t[WORD_BITS-1:0];
    endfunction

    // Each pixel's bits set when that pixel of the pattern is nonzero.
    function automatic logic [WORD_BITS-1:0] nz_mask(input logic [WORD_BITS-1:0] p,
                                                     input logic [2:0] l);
        logic [15:0] o2;
        logic [7:0]  o4;
        logic [3:0]  o8;
        logic [1:0]  o16;
        logic        o32;
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < 16; i++) o2[i]  = p[2*i] | p[2*i+1];
        for (int i = 0; i < 8; i++)  o4[i]  = o2[2*i] | o2[2*i+1];
        for (int i = 0; i < 4; i++)  o8[i]  = o4[2*i] | o4[2*i+1];
        for (int i = 0; i < 2; i++)  o16[i] = o8[2*i] | o8[2*i+1];
        o32 = o16[0] | o16[1];
        for (int b = 0; b < WORD_BITS; b++) begin
            case (l)
                3'd0:    m[b] = p[b];
                3'd1:    m[b] = o2[b >> 1];
                3'd2:    m[b] = o4[b >> 2];
                3'd3:    m[b] = o8[b >> 3];
                3'd4:    m[b] = o16[b >> 4];
                default: m[b] = o32;
            endcase
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/ppsr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ppsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/ppsr_merge.sv
// Pen-mode merge of a pattern into one stored word over a bit field.
// Depends on ppsr_pkg.
module ppsr_merge (
    input  logic [ppsr_pkg::WORD_BITS-1:0] i_cur,
    input  ppsr_pkg::t_merge_ctl           i_ctl,
    output logic [ppsr_pkg::WORD_BITS-1:0] o_word
);
    import ppsr_pkg::*;

    logic [WORD_BITS-1:0] w_data;
    logic [WORD_BITS-1:0] w_nzf;

    assign w_data = i_ctl.pattern & i_ctl.field;
    assign w_nzf  = i_ctl.field & i_ctl.nz;

    always_comb begin
        case (i_ctl.pen)
            PEN_ERASE:      o_word = i_cur & ~w_data;
            PEN_INVERT:     o_word = i_cur ^ w_data;
            PEN_BLEND:      o_word = i_cur | w_data;
            PEN_ZERO_TRANS: o_word = (i_cur & ~w_nzf) | (i_ctl.pattern & w_nzf);
            default:        o_word = (i_cur & ~i_ctl.field) | w_data;
        endcase
    end

endmodule

FILE: rtl/core/packed_pixel_span_raster_op_core.sv
// Packed-pixel framebuffer core with word access, pixel read and span fill.
// Items are handled one at a time: no new item is taken until the result of the
// last one has been registered at the output.
// A span does one read-modify-write per word per cycle through the store RAM.
// Reset: registers to bpp_log2 0, row_words 4, pen_mode 0, then a clearing pass
// zeroes every word of the store; no item is taken until it ends.
module packed_pixel_span_raster_op_core #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_word_addr,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [11:0] i_span_pixels,
    input  logic [31:0] i_data_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import ppsr_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [IDX_W-1:0] STORE_LIM = IDX_W'(STORE_WORDS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_WORDS - 1);

    t_state r_state, n_state;

    logic [2:0]  r_bpp_log2;
    logic [12:0] r_row_words;
    logic [2:0]  r_pen_mode;

    logic [1:0]           r_kind;
    logic [11:0]          r_addr;
    logic [11:0]          r_x;
    logic [11:0]          r_y;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_data;

    logic [PROD_W-1:0]    r_prod;
    logic [XBITS_W-1:0]   r_xbits;
    logic [IDX_W-1:0]     r_word;
    logic [SH_W-1:0]      r_sh;
    logic [WORD_BITS-1:0] r_nz;
    logic [CNT_W-1:0]     r_rem;

    logic                 r_pv;
    logic                 r_pok;
    logic [AW-1:0]        r_paddr;
    logic [WORD_BITS-1:0] r_pfield;

    logic [WORD_BITS-1:0] r_res;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_data;
    logic [AW-1:0]        r_clr;

    logic [2:0]           w_l;
    logic                 w_accept;
    logic                 w_in_range;
    logic                 w_span_issue;
    logic                 w_out_free;
    logic [5:0]           w_avail;
    logic [XBITS_W-1:0]   w_need;
    logic [5:0]           w_tb;
    logic [5:0]           w_hi;
    logic [WORD_BITS-1:0] w_field;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_merged;
    logic [WORD_BITS-1:0] w_rd_result;
    t_merge_ctl           w_mctl;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    assign w_l        = (r_bpp_log2 > BPP_LOG2_MAX) ? BPP_LOG2_MAX : r_bpp_log2;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = r_word < STORE_LIM;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_data;

    // span word field
    assign w_avail = 6'd32 - {1'b0, r_sh};
    assign w_need  = XBITS_W'(r_rem) << w_l;
    assign w_tb    = (w_need < XBITS_W'(w_avail)) ? w_need[5:0] : w_avail;
    assign w_hi    = {1'b0, r_sh} + w_tb;
    assign w_field = low_mask(w_hi) & ~low_mask({1'b0, r_sh});

    assign w_mctl.pen     = r_pen_mode;
    assign w_mctl.field   = r_pfield;
    assign w_mctl.nz      = r_nz;
    assign w_mctl.pattern = r_data;

    ppsr_merge u_merge (
        .i_cur  (w_rdata),
        .i_ctl  (w_mctl),
        .o_word (w_merged)
    );

    ppsr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_word[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (!w_in_range) begin
            w_rd_result = '0;
        end else if (r_kind == KIND_RD_PIX) begin
            w_rd_result = (w_rdata >> r_sh) & low_mask(6'd1 << w_l);
        end else begin
            w_rd_result = w_rdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == LAST_ADDR) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADDR;
            ST_ADDR:  n_state = (r_kind == KIND_SPAN) ? ST_SPAN : ST_ISSUE;
            ST_ISSUE: n_state = (r_kind == KIND_WR_WORD) ? ST_DONE : ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_SPAN:  if (r_rem == '0 && !r_pv) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_span_issue = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_paddr;
        w_wdata      = w_merged;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_ISSUE: begin
                w_we    = (r_kind == KIND_WR_WORD) && w_in_range;
                w_waddr = r_word[AW-1:0];
                w_wdata = r_data;
            end
            ST_SPAN: begin
                w_span_issue = (r_rem != '0);
                w_we         = r_pv && r_pok;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_bpp_log2  <= 3'd0;
            r_row_words <= 13'd4;
            r_pen_mode  <= PEN_ASSIGN;
            r_clr       <= '0;
            r_rem       <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BPP_LOG2:  r_bpp_log2  <= i_cfg_data[2:0];
                    CFG_ROW_WORDS: r_row_words <= i_cfg_data;
                    CFG_PEN_MODE:  r_pen_mode  <= i_cfg_data[2:0];
                    default:       r_pen_mode  <= r_pen_mode;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_ADDR) begin
                r_rem <= (r_kind == KIND_SPAN) ? r_cnt : '0;
            end else if (w_span_issue) begin
                r_rem <= r_rem - CNT_W'(w_tb >> w_l);
            end
            r_pv <= w_span_issue;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_addr <= i_word_addr;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_cnt  <= i_span_pixels;
            r_data <= i_data_word;
            r_res  <= '0;
        end
        if (r_state == ST_MUL) begin
            r_prod  <= r_y * r_row_words;
            r_xbits <= XBITS_W'(r_x) << w_l;
        end
        if (r_state == ST_ADDR) begin
            r_nz <= nz_mask(r_data, w_l);
            if (r_kind == KIND_SPAN || r_kind == KIND_RD_PIX) begin
                r_word <= IDX_W'(r_prod) + IDX_W'(r_xbits[XBITS_W-1:SH_W]);
                r_sh   <= r_xbits[SH_W-1:0];
            end else begin
                r_word <= IDX_W'(r_addr);
                r_sh   <= '0;
            end
        end else if (w_span_issue) begin
            r_word   <= r_word + 1'b1;
            r_sh     <= '0;
            r_paddr  <= r_word[AW-1:0];
            r_pok    <= w_in_range;
            r_pfield <= w_field;
        end
        if (r_state == ST_RDATA) begin
            r_res <= w_rd_result;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= r_res;
        end
    end

endmodule

FILE: rtl/core/ppsr_checker.sv
// Port-level checker for the span raster-op core, bound to the top level.
// Depends on packed_pixel_span_raster_op_core_macros.svh.
`include "packed_pixel_span_raster_op_core_macros.svh"

module ppsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_value
);

    `PPSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_read_value))
    `PPSR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `PPSR_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_in_valid && o_in_ready, !$rose(o_out_valid))
    `PPSR_ASSERT_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, !o_in_ready && !o_out_valid)

endmodule

bind packed_pixel_span_raster_op_core ppsr_checker u_ppsr_checker (.*);
